>>> src/ncbf_pkg.sv
// Package for the nearest containing bar finder.
// Holds field widths, the default history depth and the compare unit result type.
// No dependencies.
package ncbf_pkg;

  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned DIST_W    = 7;
  localparam int unsigned DEPTH_DEF = 64;

  typedef struct packed {
    logic               hit;
    logic [PRICE_W-1:0] span_hi;
    logic [PRICE_W-1:0] span_lo;
  } cmp_res_t;

endpackage

>>> src/nearest_containing_bar_finder.sv
// Nearest containing bar finder. Each accepted bar is compared against the held
// bars of its series, newest first, and the result is the number of bars back to
// the nearest one whose high and low bound every bar from it through the new one
// (0 if no held bar does). One bar is in work at a time: after the transfer the
// block passes through a read state and a compare state for each held bar examined
// (none for the first bar of a series or an empty history, otherwise 1 to DEPTH,
// stopping at the first containing bar), then a write state that stores the bar in
// the history and loads the result, and only then takes the next bar. The steps
// follow from the single-port history memory, read one entry at a time with a
// registered read, feeding one shared compare unit. A finished result sits in
// an output register and the next bar may be taken while it waits; if that result
// is still stalled when the next one is done, the block holds until it is taken.
// Depends on ncbf_pkg and ncbf_cmp.
module nearest_containing_bar_finder
  import ncbf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PRICE_W-1:0] bar_high_i,
  input  logic [PRICE_W-1:0] bar_low_i,
  input  logic               first_bar_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DIST_W-1:0]  distance_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [AW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [CW-1:0]        held_q, held_d;
  logic [CW-1:0]        k_q, k_d;
  logic [CW-1:0]        k_inc;
  logic [DIST_W-1:0]    dist_q, dist_d;
  logic [PRICE_W-1:0]   hi_q, hi_d, lo_q, lo_d;
  logic [PRICE_W-1:0]   span_hi_q, span_hi_d, span_lo_q, span_lo_d;
  logic                 out_valid_q, out_valid_d;
  logic [DIST_W-1:0]    distance_q, distance_d;
  logic [2*PRICE_W-1:0] rd_data_q;
  logic [2*PRICE_W-1:0] hist_mem [DEPTH];

  logic     in_xfer;
  logic     out_free;
  logic     rd_en;
  logic     wr_en;
  logic [AW-1:0] newest;
  cmp_res_t cmp_res;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;

  assign newest = (wr_ptr_q == '0) ? AW'(DEPTH - 1) : wr_ptr_q - 1'b1;
  assign k_inc  = k_q + 1'b1;
  assign rd_en  = (state_q == S_RD);
  assign wr_en  = (state_q == S_WR) && out_free;

  ncbf_cmp u_cmp (
    .held_hi_i (rd_data_q[2*PRICE_W-1:PRICE_W]),
    .held_lo_i (rd_data_q[PRICE_W-1:0]),
    .span_hi_i (span_hi_q),
    .span_lo_i (span_lo_q),
    .res_o     (cmp_res)
  );

  // History ring: a write in the write state and a registered read in the read state, never both at once.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_ptr_q] <= {hi_q, lo_q};
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[addr_q];
    end
  end

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    addr_d      = addr_q;
    held_d      = held_q;
    k_d         = k_q;
    dist_d      = dist_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    span_hi_d   = span_hi_q;
    span_lo_d   = span_lo_q;
    out_valid_d = out_valid_q;
    distance_d  = distance_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          hi_d      = bar_high_i;
          lo_d      = bar_low_i;
          span_hi_d = bar_high_i;
          span_lo_d = bar_low_i;
          k_d       = '0;
          addr_d    = newest;
          dist_d    = '0;
          if (first_bar_i) begin
            held_d = '0;
          end
          if (first_bar_i || held_q == '0) begin
            state_d = S_WR;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        // Step the read pointer back toward older bars.
        addr_d  = (addr_q == '0) ? AW'(DEPTH - 1) : addr_q - 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        span_hi_d = cmp_res.span_hi;
        span_lo_d = cmp_res.span_lo;
        k_d       = k_inc;
        if (cmp_res.hit) begin
          dist_d  = DIST_W'(k_inc);
          state_d = S_WR;
        end else if (k_inc == held_q) begin
          state_d = S_WR;
        end else begin
          state_d = S_RD;
        end
      end
      S_WR: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          wr_ptr_d    = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
          if (held_q != CW'(DEPTH)) begin
            held_d = held_q + 1'b1;
          end
          out_valid_d = 1'b1;
          distance_d  = dist_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_ptr_q    <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    k_q        <= k_d;
    dist_q     <= dist_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    span_hi_q  <= span_hi_d;
    span_lo_q  <= span_lo_d;
    distance_q <= distance_d;
  end

endmodule

>>> src/ncbf_cmp.sv
// Shared compare unit of the nearest containing bar finder.
// Checks one held bar against the running span and widens the span.
// Depends on ncbf_pkg.
module ncbf_cmp
  import ncbf_pkg::*;
(
  input  logic [PRICE_W-1:0] held_hi_i,
  input  logic [PRICE_W-1:0] held_lo_i,
  input  logic [PRICE_W-1:0] span_hi_i,
  input  logic [PRICE_W-1:0] span_lo_i,
  output cmp_res_t           res_o
);

  logic hi_ge;
  logic lo_le;

  assign hi_ge = (held_hi_i >= span_hi_i);
  assign lo_le = (held_lo_i <= span_lo_i);

  // The held bar contains the span exactly when it bounds the old span on both sides.
  always_comb begin
    res_o.hit     = hi_ge && lo_le;
    res_o.span_hi = hi_ge ? held_hi_i : span_hi_i;
    res_o.span_lo = lo_le ? held_lo_i : span_lo_i;
  end

endmodule

>>> src/ncbf_checker.sv
// Port-level checker for the nearest containing bar finder, bound to the top level.
// Depends on ncbf_pkg and nearest_containing_bar_finder.
module ncbf_checker
  import ncbf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [PRICE_W-1:0] bar_high_i,
  input logic [PRICE_W-1:0] bar_low_i,
  input logic               first_bar_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [DIST_W-1:0]  distance_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o))
    else $error("result changed while stalled");

  // Distance never reaches past the held history.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 127) || (distance_o <= DIST_W'(DEPTH)))
    else $error("distance beyond history depth");

  // A transfer keeps the block busy on the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken without work cycle");

  // A new result appears only after an item was in work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

  // A series start turns the input busy right away.
  a_first_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && first_bar_i |=> in_stall_o && !$stable(in_stall_o))
    else $error("series start not processed");

endmodule

bind nearest_containing_bar_finder ncbf_checker #(.DEPTH(DEPTH)) u_ncbf_checker (.*);
